FILE: src/gbba_pkg.sv
// ----------------------------------------------------------------------------
// gbba_pkg
// Shared sizes, codes, types and helpers of the grouped bitmap block allocator.
// ----------------------------------------------------------------------------
package gbba_pkg;

  localparam int GROUPS           = 8;
  localparam int BLOCKS_PER_GROUP = 256;
  localparam int WORD_BITS        = 32;
  localparam int FILE_SLOTS       = 16;
  localparam int PREALLOC_RUN     = 8;

  localparam int WPG        = BLOCKS_PER_GROUP / WORD_BITS;
  localparam int NWORDS     = GROUPS * WPG;
  localparam int ADDR_W     = $clog2(NWORDS);
  localparam int GRP_W      = $clog2(GROUPS);
  localparam int WIDX_W     = $clog2(WPG);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int OFF_W      = $clog2(BLOCKS_PER_GROUP);
  localparam int BLK_W      = 12;
  localparam int GCNT_W     = OFF_W + 1;
  localparam int SLOT_W     = $clog2(FILE_SLOTS);
  localparam int RUN_W      = $clog2(PREALLOC_RUN);
  localparam int PREALLOC_MIN = PREALLOC_RUN * 4;
  localparam int TOTAL_BLOCKS = GROUPS * BLOCKS_PER_GROUP;

  // commands
  localparam logic [2:0] CMD_ALLOC    = 3'd0;
  localparam logic [2:0] CMD_FREE     = 3'd1;
  localparam logic [2:0] CMD_DROP     = 3'd2;
  localparam logic [2:0] CMD_DROP_ALL = 3'd3;
  localparam logic [2:0] CMD_ALLOW    = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_SPACE = 3'd1;
  localparam logic [2:0] ST_RO       = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_DBL_FREE = 3'd4;

  // register indexes
  localparam logic [2:0] REG_FDB   = 3'd0;
  localparam logic [2:0] REG_TOTAL = 3'd1;
  localparam logic [2:0] REG_GRPS  = 3'd2;
  localparam logic [2:0] REG_IPG   = 3'd3;
  localparam logic [2:0] REG_RES   = 3'd4;
  localparam logic [2:0] REG_USE   = 3'd5;
  localparam logic [2:0] REG_RO    = 3'd6;

  // one bitmap access; addr is shared, read and write never in one cycle
  typedef struct packed {
    logic                 re;
    logic                 we;
    logic [ADDR_W-1:0]    addr;
    logic [WORD_BITS-1:0] wdata;
  } bm_req_t;

  // {found, index} of the lowest zero bit
  function automatic logic [BIT_W:0] first_zero(input logic [WORD_BITS-1:0] v);
    logic [BIT_W:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!v[i]) begin
        r = {1'b1, BIT_W'(i)};
      end
    end
    return r;
  endfunction

endpackage

FILE: src/gbba_bitmap.sv
// ----------------------------------------------------------------------------
// gbba_bitmap
// Used-block bitmap: single-port word memory, registered read, per-word valid.
// ----------------------------------------------------------------------------
module gbba_bitmap
  import gbba_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bm_req_t              req_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [NWORDS-1:0]    valid_q;
  logic [WORD_BITS-1:0] raw_q;
  logic                 rvld_q;

  // unwritten words read as all free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.addr] <= 1'b1;
      end
      if (req_i.re) begin
        rvld_q <= valid_q[req_i.addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      raw_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rvld_q ? raw_q : '0;

endmodule

FILE: src/gbba_div.sv
// ----------------------------------------------------------------------------
// gbba_div
// Restoring 16-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gbba_div
  import gbba_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [15:0] quotient_o
);

  logic [16:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic [15:0] dsr_q;
  logic [4:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [16:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    trial  = {rem_q[15:0], quo_q[15]};
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = 5'd16;
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = trial - {1'b0, dsr_q};
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[14:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: src/grouped_bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// grouped_bitmap_block_allocator
// Grouped used-block bitmap allocator with per-slot preallocation runs.
// ----------------------------------------------------------------------------
// Sequencing: a simple request needs no bitmap access; a free in range reads
//   one bitmap word and writes it back unless the block is already free; an
//   allocate reads bitmap words over the groups scanned (up to ~9 groups x 16
//   reads), after a goal-group divide when no goal is given; discard-all walks
//   all 16 slots and returns each remaining block of their runs.
// Throughput: one request at a time; the single bitmap port sets the pace.
// Reset: bitmap reads as all free at once (per-word valid flops), counts,
//   hint, slot state and registers take their reset values; no clearing pass.
module grouped_bitmap_block_allocator
  import gbba_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // request
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         command_i,
  input  logic [SLOT_W-1:0]  file_slot_i,
  input  logic [15:0]        file_number_i,
  input  logic [BLK_W-1:0]   goal_block_i,
  input  logic [BLK_W-1:0]   freed_block_i,
  // result
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [BLK_W-1:0]   block_out_o,
  output logic [2:0]         status_o
);

  // sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_DA_NEXT = 5'd2;
  localparam logic [4:0] S_DA_STEP = 5'd3;
  localparam logic [4:0] S_DS_INIT = 5'd4;
  localparam logic [4:0] S_DS_LOOP = 5'd5;
  localparam logic [4:0] S_GB_START= 5'd6;
  localparam logic [4:0] S_GB_CK   = 5'd7;
  localparam logic [4:0] S_A_CHK   = 5'd8;
  localparam logic [4:0] S_A_DIVW  = 5'd9;
  localparam logic [4:0] S_A_GOAL  = 5'd10;
  localparam logic [4:0] S_GRP     = 5'd11;
  localparam logic [4:0] S_BYTE_RD = 5'd12;
  localparam logic [4:0] S_BYTE_CK = 5'd13;
  localparam logic [4:0] S_BIT_RD  = 5'd14;
  localparam logic [4:0] S_BIT_CK  = 5'd15;
  localparam logic [4:0] S_FIN     = 5'd16;

  // ---------------- configuration registers ----------------
  logic              fdb_q;
  logic [BLK_W-1:0]  bt_q;
  logic [3:0]        grps_q;
  logic [15:0]       ipg_q;
  logic [BLK_W-1:0]  res_q;
  logic              ur_q;
  logic              ro_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fdb_q  <= 1'b1;
      bt_q   <= 12'd2049;
      grps_q <= 4'd8;
      ipg_q  <= 16'd256;
      res_q  <= '0;
      ur_q   <= 1'b0;
      ro_q   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_FDB:   fdb_q  <= pwdata[0];
        REG_TOTAL: bt_q   <= pwdata[BLK_W-1:0];
        REG_GRPS:  grps_q <= pwdata[3:0];
        REG_IPG:   ipg_q  <= pwdata[15:0];
        REG_RES:   res_q  <= pwdata[BLK_W-1:0];
        REG_USE:   ur_q   <= pwdata[0];
        REG_RO:    ro_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_FDB:   prdata = {31'd0, fdb_q};
      REG_TOTAL: prdata = {20'd0, bt_q};
      REG_GRPS:  prdata = {28'd0, grps_q};
      REG_IPG:   prdata = {16'd0, ipg_q};
      REG_RES:   prdata = {20'd0, res_q};
      REG_USE:   prdata = {31'd0, ur_q};
      REG_RO:    prdata = {31'd0, ro_q};
      default:   prdata = '0;
    endcase
  end

  // groups in use, clamped to 1..GROUPS
  logic [3:0] ng;
  assign ng = (grps_q == '0) ? 4'd1 :
              (grps_q > 4'(GROUPS)) ? 4'(GROUPS) : grps_q;

  // ---------------- state ----------------
  logic [4:0]          state_q, state_d;
  logic [2:0]          cmd_q, cmd_d;
  logic [SLOT_W-1:0]   s_q, s_d;
  logic [15:0]         fnum_q, fnum_d;
  logic [BLK_W-1:0]    goalin_q, goalin_d, freed_q, freed_d;

  logic [GCNT_W-1:0]   gfc_q [GROUPS];
  logic [GCNT_W-1:0]   gfc_d [GROUPS];
  logic [BLK_W-1:0]    total_q, total_d;
  logic [BLK_W-1:0]    hint_q, hint_d;
  logic [BLK_W-1:0]    base_q [FILE_SLOTS];
  logic [BLK_W-1:0]    base_d [FILE_SLOTS];
  logic [RUN_W-1:0]    nxt_q [FILE_SLOTS];
  logic [RUN_W-1:0]    nxt_d [FILE_SLOTS];
  logic [RUN_W-1:0]    left_q [FILE_SLOTS];
  logic [RUN_W-1:0]    left_d [FILE_SLOTS];
  logic [FILE_SLOTS-1:0] allow_q, allow_d;

  // scan context
  logic [BLK_W-1:0]    goal_q, goal_d;
  logic                over_q, over_d;
  logic                upd_q, upd_d;
  logic [3:0]          sg_q, sg_d;
  logic [3:0]          it_q, it_d;
  logic [WIDX_W-1:0]   word_q, word_d;
  logic [WIDX_W-1:0]   bw_q, bw_d;

  // slot-drop / give-back context
  logic [SLOT_W-1:0]   cur_q, cur_d;
  logic [RUN_W-1:0]    j_q, j_d;
  logic [4:0]          ds_ret_q, ds_ret_d;
  logic [4:0]          da_ret_q, da_ret_d;
  logic [SLOT_W-1:0]   da_cnt_q, da_cnt_d;
  logic [BLK_W:0]      gb_blk_q, gb_blk_d;
  logic                gb_ds_q, gb_ds_d;

  // result being built and output register
  logic [BLK_W-1:0]    blk_q, blk_d;
  logic [2:0]          st_q, st_d;
  logic                out_valid_q, out_valid_d;
  logic [BLK_W-1:0]    out_blk_q, out_blk_d;
  logic [2:0]          out_st_q, out_st_d;

  // shared units
  bm_req_t              bm_req;
  logic [WORD_BITS-1:0] bm_rdata;
  logic                 div_start, div_done;
  logic [15:0]          div_q;

  gbba_bitmap u_bitmap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (bm_req),
    .rdata_o (bm_rdata)
  );

  gbba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (fnum_q - 16'd1),
    .divisor_i  (ipg_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // valid bits of the current scan group inside the volume
  logic [BLK_W-1:0]  grp_start;
  logic [BLK_W-1:0]  grp_diff;
  logic [OFF_W:0]    lim;
  assign grp_start = {1'b0, sg_q[GRP_W-1:0], {OFF_W{1'b0}}} + {{(BLK_W-1){1'b0}}, fdb_q};
  assign grp_diff  = bt_q - grp_start;
  assign lim = (bt_q <= grp_start) ? '0 :
               (grp_diff > BLK_W'(BLOCKS_PER_GROUP)) ? (OFF_W+1)'(BLOCKS_PER_GROUP) :
               grp_diff[OFF_W:0];

  // give-back decode
  logic [BLK_W-1:0]  gb_off;
  logic [3:0]        gb_g;
  logic              gb_bad;
  assign gb_off = gb_blk_q[BLK_W-1:0] - {{(BLK_W-1){1'b0}}, fdb_q};
  assign gb_g   = gb_off[BLK_W-1:OFF_W];
  assign gb_bad = (gb_blk_q < {{BLK_W{1'b0}}, fdb_q}) ||
                  (gb_blk_q >= {1'b0, bt_q}) || (gb_g >= ng);

  // goal normalisation
  logic              goal_repl, goal_upd;
  logic [BLK_W-1:0]  g1, g2, g3, goal_off;
  assign goal_repl = over_q || (goal_q >= bt_q) ||
                     ((goal_q < {{(BLK_W-1){1'b0}}, fdb_q}) && (goal_q != '0));
  assign g1       = goal_repl ? hint_q : goal_q;
  assign goal_upd = (g1 <= hint_q);
  assign g2       = goal_upd ? hint_q : g1;
  assign g3       = (g2 < {{(BLK_W-1){1'b0}}, fdb_q}) ? {{(BLK_W-1){1'b0}}, fdb_q} : g2;
  assign goal_off = g3 - {{(BLK_W-1){1'b0}}, fdb_q};

  // preallocation hit check
  logic [BLK_W:0]    pa_blk;
  logic              pa_hit;
  assign pa_blk = {1'b0, base_q[cur_q]} + {{(BLK_W-RUN_W+1){1'b0}}, nxt_q[cur_q]};
  assign pa_hit = ({1'b0, goalin_q} == pa_blk) || (({1'b0, goalin_q} + 1'b1) == pa_blk);

  // word scan helpers
  logic [BIT_W:0]    fz;
  logic [OFF_W-1:0]  bit_off;
  logic [GRP_W-1:0]  sgi;
  logic [BLK_W-1:0]  hit_blk;
  logic              byte_found;
  logic [1:0]        byte_idx;
  logic [OFF_W-1:0]  byte_off;
  logic [3:0]        gi;

  assign sgi     = sg_q[GRP_W-1:0];
  assign fz      = first_zero(bm_rdata);
  assign bit_off = {bw_q, fz[BIT_W-1:0]};
  assign gi      = (sg_q >= ng) ? 4'd0 : sg_q;

  always_comb begin
    byte_found = 1'b0;
    byte_idx   = '0;
    for (int k = 3; k >= 0; k--) begin
      if ((bm_rdata[k*8 +: 8] == 8'd0) &&
          (({1'b0, bw_q, 2'(k), 3'b000} + (OFF_W+1)'(8)) <= lim)) begin
        byte_found = 1'b1;
        byte_idx   = 2'(k);
      end
    end
  end
  assign byte_off = {bw_q, byte_idx, 3'b000};
  assign hit_blk  = {1'b0, sgi, (state_q == S_BYTE_CK) ? byte_off : bit_off} +
                    {{(BLK_W-1){1'b0}}, fdb_q};

  // ---------------- sequencer ----------------
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;   s_d = s_q;  fnum_d = fnum_q;
    goalin_d = goalin_q; freed_d = freed_q;
    gfc_d    = gfc_q;   total_d = total_q; hint_d = hint_q;
    base_d   = base_q;  nxt_d = nxt_q; left_d = left_q; allow_d = allow_q;
    goal_d   = goal_q;  over_d = over_q; upd_d = upd_q;
    sg_d     = sg_q;    it_d = it_q; word_d = word_q; bw_d = bw_q;
    cur_d    = cur_q;   j_d = j_q; ds_ret_d = ds_ret_q;
    da_ret_d = da_ret_q; da_cnt_d = da_cnt_q;
    gb_blk_d = gb_blk_q; gb_ds_d = gb_ds_q;
    blk_d    = blk_q;   st_d = st_q;
    out_valid_d = out_valid_q; out_blk_d = out_blk_q; out_st_d = out_st_q;
    bm_req    = '0;
    div_start = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = command_i;
          s_d      = file_slot_i;
          cur_d    = file_slot_i;
          fnum_d   = file_number_i;
          goalin_d = goal_block_i;
          freed_d  = freed_block_i;
          blk_d    = '0;
          st_d     = ST_OK;
          state_d  = S_DISP;
        end
      end

      S_DISP: begin
        if (ro_q && (cmd_q == CMD_ALLOC || cmd_q == CMD_FREE ||
                     cmd_q == CMD_DROP || cmd_q == CMD_DROP_ALL)) begin
          st_d    = ST_RO;
          state_d = S_FIN;
        end else begin
          case (cmd_q)
            CMD_ALLOC: begin
              // low space drops every preallocation first
              if ((!ur_q && total_q <= res_q) || total_q <= BLK_W'(PREALLOC_RUN)) begin
                da_ret_d = S_A_CHK;
                da_cnt_d = '0;
                state_d  = S_DA_NEXT;
              end else begin
                state_d  = S_A_CHK;
              end
            end
            CMD_FREE: begin
              gb_blk_d = {1'b0, freed_q};
              gb_ds_d  = 1'b0;
              state_d  = S_GB_START;
            end
            CMD_DROP: begin
              ds_ret_d = S_FIN;
              state_d  = S_DS_INIT;
            end
            CMD_DROP_ALL: begin
              da_ret_d = S_FIN;
              da_cnt_d = '0;
              state_d  = S_DA_NEXT;
            end
            CMD_ALLOW: begin
              allow_d[cur_q] = 1'b1;
              state_d = S_FIN;
            end
            default: state_d = S_FIN;
          endcase
        end
      end

      // walk all slots
      S_DA_NEXT: begin
        cur_d    = da_cnt_q;
        ds_ret_d = S_DA_STEP;
        state_d  = S_DS_INIT;
      end

      S_DA_STEP: begin
        allow_d[cur_q] = 1'b0;
        if (da_cnt_q == SLOT_W'(FILE_SLOTS - 1)) begin
          cur_d   = s_q;
          state_d = da_ret_q;
        end else begin
          da_cnt_d = da_cnt_q + 1'b1;
          state_d  = S_DA_NEXT;
        end
      end

      // return the rest of slot cur's run
      S_DS_INIT: begin
        j_d     = nxt_q[cur_q];
        state_d = S_DS_LOOP;
      end

      S_DS_LOOP: begin
        if ((j_q != RUN_W'(PREALLOC_RUN - 1)) &&
            ({1'b0, j_q} < ({1'b0, nxt_q[cur_q]} + {1'b0, left_q[cur_q]}))) begin
          gb_blk_d = {1'b0, base_q[cur_q]} + {{(BLK_W-RUN_W+1){1'b0}}, j_q};
          gb_ds_d  = 1'b1;
          state_d  = S_GB_START;
        end else begin
          base_d[cur_q] = '0;
          nxt_d[cur_q]  = '0;
          left_d[cur_q] = '0;
          state_d       = ds_ret_q;
        end
      end

      // return one block to the free pool
      S_GB_START: begin
        if (gb_bad) begin
          if (gb_ds_q) begin
            j_d     = j_q + 1'b1;
            state_d = S_DS_LOOP;
          end else begin
            st_d    = ST_RANGE;
            state_d = S_FIN;
          end
        end else begin
          bm_req.re   = 1'b1;
          bm_req.addr = {gb_g[GRP_W-1:0], gb_off[OFF_W-1:BIT_W]};
          state_d     = S_GB_CK;
        end
      end

      S_GB_CK: begin
        if (!bm_rdata[gb_off[BIT_W-1:0]]) begin
          st_d = ST_DBL_FREE;
        end else begin
          bm_req.we    = 1'b1;
          bm_req.addr  = {gb_g[GRP_W-1:0], gb_off[OFF_W-1:BIT_W]};
          bm_req.wdata = bm_rdata & ~(WORD_BITS'(1) << gb_off[BIT_W-1:0]);
          gfc_d[gb_g[GRP_W-1:0]] = gfc_q[gb_g[GRP_W-1:0]] + 1'b1;
          total_d = total_q + 1'b1;
          if (gb_blk_q < {1'b0, hint_q}) begin
            hint_d = gb_blk_q[BLK_W-1:0];
          end
          st_d = ST_OK;
        end
        if (gb_ds_q) begin
          st_d    = st_q;
          j_d     = j_q + 1'b1;
          state_d = S_DS_LOOP;
        end else begin
          state_d = S_FIN;
        end
      end

      S_A_CHK: begin
        if ((!ur_q && total_q <= res_q) || total_q == '0) begin
          st_d    = ST_NO_SPACE;
          state_d = S_FIN;
        end else if (goalin_q != '0) begin
          goal_d = goalin_q;
          over_d = 1'b0;
          if (allow_q[cur_q] && left_q[cur_q] != '0) begin
            if (pa_hit) begin
              left_d[cur_q] = left_q[cur_q] - 1'b1;
              nxt_d[cur_q]  = nxt_q[cur_q] + 1'b1;
              blk_d         = pa_blk[BLK_W-1:0];
              state_d       = S_FIN;
            end else begin
              allow_d[cur_q] = 1'b0;
              ds_ret_d       = S_A_GOAL;
              state_d        = S_DS_INIT;
            end
          end else begin
            state_d = S_A_GOAL;
          end
        end else if (fnum_q == '0 || ipg_q == '0) begin
          goal_d  = {{(BLK_W-1){1'b0}}, fdb_q};
          over_d  = 1'b0;
          state_d = S_A_GOAL;
        end else begin
          div_start = 1'b1;
          state_d   = S_A_DIVW;
        end
      end

      // default goal group from the file number
      S_A_DIVW: begin
        if (div_done) begin
          over_d  = |div_q[15:4];
          goal_d  = {div_q[3:0], {OFF_W{1'b0}}} + {{(BLK_W-1){1'b0}}, fdb_q};
          state_d = S_A_GOAL;
        end
      end

      S_A_GOAL: begin
        upd_d   = goal_upd;
        sg_d    = goal_off[BLK_W-1:OFF_W];
        word_d  = goal_off[OFF_W-1:BIT_W];
        it_d    = '0;
        state_d = S_GRP;
      end

      S_GRP: begin
        if (it_q > ng) begin
          blk_d   = '0;
          st_d    = ST_NO_SPACE;
          state_d = S_FIN;
        end else if (gfc_q[gi[GRP_W-1:0]] == '0) begin
          word_d = '0;
          sg_d   = gi + 1'b1;
          it_d   = it_q + 1'b1;
        end else begin
          sg_d = gi;
          if (allow_q[cur_q] && gfc_q[gi[GRP_W-1:0]] >= GCNT_W'(PREALLOC_MIN)) begin
            bw_d = '0;
            if (left_q[cur_q] != '0) begin
              ds_ret_d = S_BYTE_RD;
              state_d  = S_DS_INIT;
            end else begin
              state_d  = S_BYTE_RD;
            end
          end else begin
            bw_d    = word_q;
            state_d = S_BIT_RD;
          end
        end
      end

      S_BYTE_RD: begin
        bm_req.re   = 1'b1;
        bm_req.addr = {sgi, bw_q};
        state_d     = S_BYTE_CK;
      end

      S_BYTE_CK: begin
        if (byte_found) begin
          bm_req.we    = 1'b1;
          bm_req.addr  = {sgi, bw_q};
          bm_req.wdata = bm_rdata | (WORD_BITS'(8'hff) << {byte_idx, 3'b000});
          base_d[cur_q] = hit_blk + 1'b1;
          nxt_d[cur_q]  = '0;
          left_d[cur_q] = RUN_W'(PREALLOC_RUN - 1);
          gfc_d[sgi] = (gfc_q[sgi] > GCNT_W'(PREALLOC_RUN)) ?
                       gfc_q[sgi] - GCNT_W'(PREALLOC_RUN) : '0;
          total_d    = (total_q > BLK_W'(PREALLOC_RUN)) ?
                       total_q - BLK_W'(PREALLOC_RUN) : '0;
          blk_d   = hit_blk;
          st_d    = (hit_blk == '0) ? ST_NO_SPACE : ST_OK;
          state_d = S_FIN;
        end else if (bw_q == WIDX_W'(WPG - 1)) begin
          bw_d    = word_q;
          state_d = S_BIT_RD;
        end else begin
          bw_d    = bw_q + 1'b1;
          state_d = S_BYTE_RD;
        end
      end

      S_BIT_RD: begin
        bm_req.re   = 1'b1;
        bm_req.addr = {sgi, bw_q};
        state_d     = S_BIT_CK;
      end

      S_BIT_CK: begin
        if (!fz[BIT_W] && bw_q != WIDX_W'(WPG - 1)) begin
          bw_d    = bw_q + 1'b1;
          state_d = S_BIT_RD;
        end else if (fz[BIT_W] && ({1'b0, bit_off} < lim)) begin
          bm_req.we    = 1'b1;
          bm_req.addr  = {sgi, bw_q};
          bm_req.wdata = bm_rdata | (WORD_BITS'(1) << fz[BIT_W-1:0]);
          gfc_d[sgi] = (gfc_q[sgi] > GCNT_W'(1)) ? gfc_q[sgi] - 1'b1 : '0;
          total_d    = (total_q > BLK_W'(1)) ? total_q - 1'b1 : '0;
          if (upd_q) begin
            hint_d = hit_blk;
          end
          blk_d   = hit_blk;
          st_d    = (hit_blk == '0) ? ST_NO_SPACE : ST_OK;
          state_d = S_FIN;
        end else begin
          // nothing usable here: next group from its first word
          word_d  = '0;
          sg_d    = sg_q + 1'b1;
          it_d    = it_q + 1'b1;
          state_d = S_GRP;
        end
      end

      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_blk_d   = blk_q;
          out_st_d    = st_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      total_q     <= BLK_W'(TOTAL_BLOCKS);
      hint_q      <= BLK_W'(1);
      allow_q     <= '0;
      for (int g = 0; g < GROUPS; g++) begin
        gfc_q[g] <= GCNT_W'(BLOCKS_PER_GROUP);
      end
      for (int s = 0; s < FILE_SLOTS; s++) begin
        base_q[s] <= '0;
        nxt_q[s]  <= '0;
        left_q[s] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
      hint_q      <= hint_d;
      allow_q     <= allow_d;
      gfc_q       <= gfc_d;
      base_q      <= base_d;
      nxt_q       <= nxt_d;
      left_q      <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;    s_q <= s_d;  fnum_q <= fnum_d;
    goalin_q <= goalin_d; freed_q <= freed_d;
    goal_q   <= goal_d;   over_q <= over_d; upd_q <= upd_d;
    sg_q     <= sg_d;     it_q <= it_d; word_q <= word_d; bw_q <= bw_d;
    cur_q    <= cur_d;    j_q <= j_d; ds_ret_q <= ds_ret_d;
    da_ret_q <= da_ret_d; da_cnt_q <= da_cnt_d;
    gb_blk_q <= gb_blk_d; gb_ds_q <= gb_ds_d;
    blk_q    <= blk_d;    st_q <= st_d;
    out_blk_q <= out_blk_d; out_st_q <= out_st_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign block_out_o = out_blk_q;
  assign status_o    = out_st_q;

  // ---------------- assertions ----------------
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a request without leaving idle");

  a_fail_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (block_out_o == '0))
    else $error("failed request carries a block number");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= BLK_W'(TOTAL_BLOCKS))
    else $error("total free count above volume size");

endmodule

FILE: verif/gbba_checker.sv
// ----------------------------------------------------------------------------
// gbba_checker
// Tracks register writes and accepted requests, predicts each request's
// block and status, and compares every returned result in order.
// ----------------------------------------------------------------------------
module gbba_checker
  import gbba_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [2:0]        command_i,
  input  logic [SLOT_W-1:0] file_slot_i,
  input  logic [15:0]       file_number_i,
  input  logic [BLK_W-1:0]  goal_block_i,
  input  logic [BLK_W-1:0]  freed_block_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [BLK_W-1:0]  block_out_i,
  input  logic [2:0]        status_i,
  input  logic              done_i,
  output int                fail_count_o
);

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    logic [2:0]       st;
  } grant_t;

  grant_t pending_grants[$];

  // register copies
  int fdb, blk_total, grps, ipg, rsv, use_rsv, ro;
  // allocator state copies
  logic [WORD_BITS-1:0] bm [NWORDS];
  int gfree [GROUPS];
  int tfree, hint;
  int pbase [FILE_SLOTS];
  int pnext [FILE_SLOTS];
  int pleft [FILE_SLOTS];
  int pallow[FILE_SLOTS];
  bit reported;
  int fails;

  assign fail_count_o = fails;

  function automatic int grp_count();
    if (grps == 0) return 1;
    if (grps > GROUPS) return GROUPS;
    return grps;
  endfunction

  function automatic int group_limit(int g);
    int start;
    start = fdb + g * BLOCKS_PER_GROUP;
    if (blk_total <= start) return 0;
    return (blk_total - start > BLOCKS_PER_GROUP) ? BLOCKS_PER_GROUP : blk_total - start;
  endfunction

  function automatic logic [2:0] give_back(int blk);
    int off, g, b;
    if (blk < fdb || blk >= blk_total) return ST_RANGE;
    off = blk - fdb;
    g = off / BLOCKS_PER_GROUP;
    b = off % BLOCKS_PER_GROUP;
    if (g >= grp_count()) return ST_RANGE;
    if (!bm[g*WPG + b/WORD_BITS][b%WORD_BITS]) return ST_DBL_FREE;
    bm[g*WPG + b/WORD_BITS][b%WORD_BITS] = 1'b0;
    gfree[g]++;
    tfree++;
    if (blk < hint) hint = blk;
    return ST_OK;
  endfunction

  function automatic void drop_slot(int s);
    logic [2:0] st;
    for (int j = pnext[s]; j < pnext[s] + pleft[s] && j < PREALLOC_RUN - 1; j++)
      st = give_back(pbase[s] + j);
    pleft[s] = 0;
    pnext[s] = 0;
    pbase[s] = 0;
  endfunction

  function automatic void drop_all();
    for (int s = 0; s < FILE_SLOTS; s++) begin
      drop_slot(s);
      pallow[s] = 0;
    end
  endfunction

  function automatic void take(int g, int n);
    gfree[g] = (gfree[g] > n) ? gfree[g] - n : 0;
    tfree    = (tfree > n) ? tfree - n : 0;
  endfunction

  // lowest zero bit from word w on; gives up if it lies past the limit
  function automatic int find_bit(int g, int w, int lim);
    logic [WORD_BITS-1:0] v;
    int b;
    for (; w < WPG; w++) begin
      v = bm[g*WPG + w];
      if (&v) continue;
      for (int k = 0; k < WORD_BITS; k++) begin
        if (!v[k]) begin
          b = w * WORD_BITS + k;
          return (b < lim) ? b : -1;
        end
      end
    end
    return -1;
  endfunction

  function automatic int find_byte(int g, int lim);
    int b;
    for (int k = 0; (k + 1) * 8 <= lim; k++) begin
      b = k * 8;
      if (((bm[g*WPG + b/WORD_BITS] >> (b % WORD_BITS)) & 8'hff) == 0) return b;
    end
    return -1;
  endfunction

  function automatic int scan_alloc(int goal, int s);
    int ng, g, word, lim, bitn, blk;
    bit upd;
    ng = grp_count();
    upd = 0;
    if (goal >= blk_total || (goal < fdb && goal != 0)) goal = hint;
    if (goal <= hint) begin
      goal = hint;
      upd = 1;
    end
    if (goal < fdb) goal = fdb;
    word = ((goal - fdb) % BLOCKS_PER_GROUP) / WORD_BITS;
    g = (goal - fdb) / BLOCKS_PER_GROUP;
    for (int i = 0; i <= ng; i++) begin
      if (i > 0) g++;
      if (g >= ng) g = 0;
      if (gfree[g] == 0) begin
        word = 0;
        continue;
      end
      lim = group_limit(g);
      // roomy group: claim a whole free byte, first block out, seven kept
      if (pallow[s] != 0 && gfree[g] >= PREALLOC_MIN) begin
        if (pleft[s] != 0) drop_slot(s);
        bitn = find_byte(g, lim);
        if (bitn >= 0) begin
          blk = fdb + g * BLOCKS_PER_GROUP + bitn;
          for (int k = 0; k < PREALLOC_RUN; k++)
            bm[g*WPG + (bitn+k)/WORD_BITS][(bitn+k)%WORD_BITS] = 1'b1;
          pbase[s] = blk + 1;
          pnext[s] = 0;
          pleft[s] = PREALLOC_RUN - 1;
          take(g, PREALLOC_RUN);
          return blk;
        end
      end
      bitn = find_bit(g, word, lim);
      if (bitn < 0) begin
        word = 0;
        continue;
      end
      bm[g*WPG + bitn/WORD_BITS][bitn%WORD_BITS] = 1'b1;
      take(g, 1);
      blk = fdb + g * BLOCKS_PER_GROUP + bitn;
      if (upd) hint = blk;
      return blk;
    end
    return 0;
  endfunction

  function automatic grant_t predict_grant(logic [2:0] cmd, int s, int fnum,
                                           int goalin, int freed);
    grant_t r;
    int goal, b, gg, blk;
    bit lowres, done;
    blk = 0;
    r.st = ST_OK;
    if (cmd <= CMD_DROP_ALL && ro != 0) begin
      r.st = ST_RO;
    end else if (cmd == CMD_ALLOC) begin
      lowres = (use_rsv == 0) && tfree <= rsv;
      // low space: every slot's run goes back first
      if (lowres || tfree <= PREALLOC_RUN) drop_all();
      if (((use_rsv == 0) && tfree <= rsv) || tfree == 0) begin
        r.st = ST_NO_SPACE;
      end else begin
        done = 0;
        goal = 0;
        if (goalin != 0) begin
          goal = goalin;
          if (pallow[s] != 0 && pleft[s] > 0) begin
            b = pbase[s] + pnext[s];
            if (goalin == b || goalin + 1 == b) begin
              pleft[s]--;
              pnext[s]++;
              if (pnext[s] >= PREALLOC_RUN) pnext[s] = 0;
              blk = b;
              done = 1;
            end else begin
              pallow[s] = 0;
              drop_slot(s);
            end
          end
        end else begin
          gg = (fnum == 0 || ipg == 0) ? 0 : (fnum - 1) / ipg;
          goal = BLOCKS_PER_GROUP * gg + fdb;
        end
        if (!done) begin
          blk = scan_alloc(goal, s);
          if (blk == 0) r.st = ST_NO_SPACE;
        end
      end
    end else if (cmd == CMD_FREE) begin
      r.st = give_back(freed);
    end else if (cmd == CMD_DROP) begin
      drop_slot(s);
    end else if (cmd == CMD_DROP_ALL) begin
      drop_all();
    end else if (cmd == CMD_ALLOW) begin
      pallow[s] = 1;
    end
    r.blk = blk[BLK_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t got, want;
    if (!rst_ni) begin
      fdb = 1; blk_total = 2049; grps = 8; ipg = 256; rsv = 0; use_rsv = 0; ro = 0;
      for (int i = 0; i < NWORDS; i++) bm[i] = '0;
      for (int i = 0; i < GROUPS; i++) gfree[i] = BLOCKS_PER_GROUP;
      tfree = TOTAL_BLOCKS;
      hint = 1;
      for (int i = 0; i < FILE_SLOTS; i++) begin
        pbase[i] = 0; pnext[i] = 0; pleft[i] = 0; pallow[i] = 0;
      end
      pending_grants.delete();
      fails = 0;
      reported = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_FDB:   fdb       = pwdata[0];
          REG_TOTAL: blk_total = pwdata[11:0];
          REG_GRPS:  grps      = pwdata[3:0];
          REG_IPG:   ipg       = pwdata[15:0];
          REG_RES:   rsv       = pwdata[11:0];
          REG_USE:   use_rsv   = pwdata[0];
          REG_RO:    ro        = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        pending_grants.push_back(predict_grant(command_i, file_slot_i % FILE_SLOTS,
                                               file_number_i, goal_block_i, freed_block_i));
      if (out_valid_i && out_ready_i) begin
        got.blk = block_out_i;
        got.st  = status_i;
        if (pending_grants.size() == 0) begin
          $error("unexpected result: block_out %0d status %0d", got.blk, got.st);
          fails++;
        end else begin
          want = pending_grants.pop_front();
          if (got.blk !== want.blk) begin
            $error("block_out: expected %0d, actual %0d", want.blk, got.blk);
            fails++;
          end
          if (got.st !== want.st) begin
            $error("status: expected %0d, actual %0d", want.st, got.st);
            fails++;
          end
        end
      end
      if (done_i && !reported) begin
        reported = 1;
        if (pending_grants.size() != 0) begin
          $error("%0d results never returned", pending_grants.size());
          fails++;
        end
      end
    end
  end

endmodule

FILE: verif/tb_grouped_bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// tb_grouped_bitmap_block_allocator
// Drives directed and random allocate/free/discard requests through a series
// of register settings with random idling on both sides; gbba_checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_grouped_bitmap_block_allocator;
  import gbba_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 600;  // covers the slowest scan or discard-all

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // configuration port
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // request / result channels
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        command = CMD_ALLOC;
  logic [SLOT_W-1:0] file_slot = '0;
  logic [15:0]       file_number = 16'd1;
  logic [BLK_W-1:0]  goal_block = '0;
  logic [BLK_W-1:0]  freed_block = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BLK_W-1:0]  block_out;
  logic [2:0]        status;

  logic done = 1'b0;
  int   fail_count;

  // stimulus bookkeeping
  int  n_sent, n_back, n_settings, n_granted, n_nospace, n_rejected, cycles;
  bit  valid_high;     // valid left high for a back-to-back request
  bit  burst;          // no idling on either side
  bit  hold_req;       // ask the receiver for a long hold-off
  int  slot_fifo[$];   // slot of each request still in flight
  int  granted_pool[$];// blocks handed out, candidates for free
  int  last_blk[FILE_SLOTS];

  grouped_bitmap_block_allocator i_dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .command_i(command), .file_slot_i(file_slot), .file_number_i(file_number),
    .goal_block_i(goal_block), .freed_block_i(freed_block),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .block_out_o(block_out), .status_o(status)
  );

  gbba_checker i_checker (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .command_i(command), .file_slot_i(file_slot), .file_number_i(file_number),
    .goal_block_i(goal_block), .freed_block_i(freed_block),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .block_out_i(block_out), .status_i(status),
    .done_i(done), .fail_count_o(fail_count)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // run guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side bookkeeping: remember granted blocks per slot so later
  // requests can hit the preallocated run and free real blocks
  always @(posedge clk_i) begin
    int s;
    if (out_valid && out_ready) begin
      n_back++;
      s = (slot_fifo.size() != 0) ? slot_fifo.pop_front() : 0;
      if (status == ST_OK && block_out != 0) begin
        n_granted++;
        last_blk[s] = block_out;
        granted_pool.push_back(block_out);
      end
      if (status == ST_NO_SPACE) n_nospace++;
      if (status == ST_RO || status == ST_RANGE || status == ST_DBL_FREE) n_rejected++;
    end
  end

  // receiver: random stall per result, plus one long hold-off on request
  initial begin
    int d;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      d = burst ? 0 : $urandom_range(0, 5);
      if (d > 0) begin
        out_ready <= 1'b0;
        repeat (d) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
    end
  end

  // one request; returns once the block has taken it and any random gap is over
  task automatic send(logic [2:0] cmd, int slot, int fnum, int goal, int freed);
    int gap;
    in_valid    <= 1'b1;
    command     <= cmd;
    file_slot   <= slot[SLOT_W-1:0];
    file_number <= fnum[15:0];
    goal_block  <= goal[BLK_W-1:0];
    freed_block <= freed[BLK_W-1:0];
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    n_sent++;
    slot_fifo.push_back(slot % FILE_SLOTS);
    gap = burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      valid_high = 0;
      repeat (gap) @(posedge clk_i);
    end else begin
      valid_high = 1;
    end
  endtask

  // stop offering and wait until every request has come back
  task automatic wait_idle();
    if (valid_high) begin
      in_valid <= 1'b0;
      valid_high = 0;
    end
    @(posedge clk_i);
    while (n_sent != n_back) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] idx, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // full register setting, only with the block idle
  task automatic configure(int fdb, int total, int grps, int ipg, int rsv,
                           int use_rsv, int ro);
    wait_idle();
    apb_write(REG_FDB, fdb);
    apb_write(REG_TOTAL, total);
    apb_write(REG_GRPS, grps);
    apb_write(REG_IPG, ipg);
    apb_write(REG_RES, rsv);
    apb_write(REG_USE, use_rsv);
    apb_write(REG_RO, ro);
    n_settings++;
  endtask

  // mostly well-formed traffic: a few busy slots chaining allocations into
  // their runs, frees of granted blocks, plus random noise
  task automatic random_request();
    int r, slot, goal, freed, fnum, idx;
    logic [2:0] cmd;
    slot  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 15);
    fnum  = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 65535) : $urandom_range(1, 600);
    goal  = 0;
    freed = 0;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      cmd = CMD_ALLOC;
      r = $urandom_range(0, 9);
      if (r < 3)      goal = 0;
      else if (r < 7) goal = last_blk[slot] + 1;
      else if (r < 8) goal = last_blk[slot];
      else            goal = $urandom_range(0, 4095);
    end else if (r < 70) begin
      cmd = CMD_FREE;
      if (granted_pool.size() != 0 && $urandom_range(0, 9) < 7) begin
        idx = $urandom_range(0, granted_pool.size() - 1);
        freed = granted_pool[idx];
        granted_pool.delete(idx);
      end else begin
        freed = $urandom_range(0, 4095);
      end
    end else if (r < 78) begin
      cmd = CMD_DROP;
    end else if (r < 80) begin
      cmd = CMD_DROP_ALL;
    end else if (r < 94) begin
      cmd = CMD_ALLOW;
    end else begin
      cmd = 3'($urandom_range(5, 7));
    end
    send(cmd, slot, fnum, goal, freed);
  endtask

  task automatic random_phase(int count, bit pressure);
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      // receiver stops for a long while, sender keeps pushing
      if (pressure && n == 20) hold_req = 1;
      // sender pauses until the block has drained
      if (pressure && n == 80) wait_idle();
      random_request();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset setting, every command and the edge cases
    send(CMD_ALLOC, 0, 1, 0, 0);
    send(CMD_ALLOC, 1, 65535, 0, 0);       // goal group past the volume
    send(CMD_ALLOC, 1, 0, 0, 0);           // file number zero
    send(CMD_ALLOC, 15, 300, 2048, 0);     // top valid goal
    send(CMD_ALLOC, 4, 300, 4095, 0);      // goal beyond the volume
    send(CMD_FREE, 0, 1, 0, 2);
    send(CMD_FREE, 0, 1, 0, 0);            // below first data block
    send(CMD_FREE, 0, 1, 0, 2049);         // at volume end
    send(CMD_FREE, 0, 1, 0, 4095);
    send(CMD_FREE, 0, 1, 0, 700);          // already free
    send(CMD_ALLOW, 2, 1, 0, 0);
    send(CMD_ALLOC, 2, 513, 0, 0);         // claims a whole byte
    wait_idle();
    send(CMD_ALLOC, 2, 513, last_blk[2] + 1, 0);  // takes the next block of the run
    send(CMD_ALLOC, 2, 513, last_blk[2] + 1, 0);
    send(CMD_ALLOC, 2, 513, 100, 0);       // mismatch drops the run
    send(CMD_ALLOW, 3, 1, 0, 0);
    send(CMD_ALLOC, 3, 1, 0, 0);
    send(CMD_DROP, 3, 1, 0, 0);
    send(CMD_ALLOW, 5, 1, 0, 0);
    send(CMD_ALLOC, 5, 1, 0, 0);
    send(CMD_DROP_ALL, 0, 1, 0, 0);
    send(3'd5, 0, 1, 0, 0);
    send(3'd7, 15, 65535, 4095, 4095);

    random_phase(140, 1'b1);
    configure(0, 2048, 8, 1, 0, 0, 0);
    random_phase(140, 1'b0);
    configure(1, 300, 2, 65535, 40, 0, 0);
    random_phase(130, 1'b0);
    configure(0, 130, 1, 0, 100, 1, 0);    // tiny volume fills up
    random_phase(130, 1'b0);
    configure(1, 4095, 15, 100, 2048, 0, 0);
    random_phase(50, 1'b0);
    configure(1, 2049, 0, 65535, 8, 1, 0);
    random_phase(100, 1'b0);
    configure(0, 0, 8, 256, 0, 0, 1);      // read only
    send(CMD_ALLOC, 0, 1, 0, 0);
    send(CMD_FREE, 0, 1, 0, 5);
    send(CMD_DROP, 0, 1, 0, 0);
    send(CMD_DROP_ALL, 0, 1, 0, 0);
    send(CMD_ALLOW, 0, 1, 0, 0);
    random_phase(40, 1'b0);
    configure(1, 2049, 8, 256, 0, 0, 0);
    random_phase(170, 1'b1);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    done <= 1'b1;
    repeat (3) @(posedge clk_i);
    $display("Covered %0d requests under %0d register settings plus reset values;",
             n_sent, n_settings);
    $display("%0d blocks granted, %0d no-space results, %0d rejected requests.",
             n_granted, n_nospace, n_rejected);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
